FILE: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the starfield projection block.
package sfp_pkg;

  localparam int NUM_STARS = 256;
  localparam int IDX_W     = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
  localparam int DATA_W    = 8;
  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = COORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0]  CENTRE_X      = 8'd160;
  localparam logic [DATA_W-1:0]  CENTRE_Y      = 8'd120;
  localparam logic [DATA_W-1:0]  SPAWN_X_OFS   = 8'd40;
  localparam logic [DATA_W-1:0]  SPAWN_DEPTH0  = 8'd255;
  localparam logic [DATA_W-1:0]  GRAY_FULL     = 8'd255;
  localparam logic [DATA_W-1:0]  DEPTH_STEP    = 8'd2;
  localparam logic [DATA_W-1:0]  DEPTH_DEAD    = 8'd1;
  localparam logic [COORD_W-1:0] SCREEN_W      = 16'd320;
  localparam logic [COORD_W-1:0] SCREEN_H      = 16'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_A       = 3'd0,
    REG_SEED_B       = 3'd1,
    REG_SEED_C       = 3'd2,
    REG_SEED_COUNTER = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_ERASE = 1'b0,
    KIND_DRAW  = 1'b1
  } pixel_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] depth;
  } star_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOOK,
    S_SPAWN_X,
    S_SPAWN_Y,
    S_DIV_X,
    S_WAIT_X,
    S_DIV_Y,
    S_WAIT_Y,
    S_CHECK,
    S_EMIT_E,
    S_EMIT_D
  } state_t;

endpackage

FILE: rtl/sfp_gen.sv
`timescale 1ns / 1ps
// Xor/add byte generator with seed loads from the configuration port.
module sfp_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          step,
  output logic [sfp_pkg::DATA_W-1:0]    value
);
  import sfp_pkg::*;

  logic [DATA_W-1:0] a_r, b_r, c_r, cnt_r;
  logic [DATA_W-1:0] a_nxt, b_nxt, c_nxt, cnt_nxt;
  logic [DATA_W-1:0] cnt_st, a_st, b_st, c_st;

  always_comb begin
    cnt_st = cnt_r + 8'd1;
    a_st   = a_r ^ c_r ^ cnt_st;
    b_st   = b_r + a_st;
    c_st   = (c_r + {1'b0, b_st[DATA_W-1:1]}) ^ a_st;
    value  = c_st;

    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    cnt_nxt = cnt_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEED_A:       a_nxt   = cfg_data;
        REG_SEED_B:       b_nxt   = cfg_data;
        REG_SEED_C:       c_nxt   = cfg_data;
        REG_SEED_COUNTER: cnt_nxt = cfg_data;
        default: ;
      endcase
    end else if (step) begin
      a_nxt   = a_st;
      b_nxt   = b_st;
      c_nxt   = c_st;
      cnt_nxt = cnt_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      c_r   <= '0;
      cnt_r <= '0;
    end else begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/sfp_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, sign applied at the end.
module sfp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sfp_pkg::div_req_t req,
  output sfp_pkg::div_rsp_t rsp
);
  import sfp_pkg::*;

  logic                 busy_r, done_r, neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    rem_r, den_r;
  logic [COORD_W-1:0]   dvd_r;
  logic [DATA_W:0]      trial;
  logic                 fit;
  logic [DATA_W-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[COORD_W-1]};
    fit     = (trial >= {1'b0, den_r});
    rem_nxt = fit ? DATA_W'(trial - {1'b0, den_r}) : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.neg;
      dvd_r <= {req.mag, {(COORD_W - DATA_W){1'b0}}};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[COORD_W-2:0], fit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? $signed(~dvd_r + 1'b1) : $signed(dvd_r);

endmodule

FILE: rtl/starfield_projection_step.sv
`timescale 1ns / 1ps
// Top level: star table, sequencer and result register of the starfield projector.
//
//   channel  direction  handshake            word
//   in_      input      in_valid/in_ready    in_frame_start
//   out_     output     out_valid/out_ready  pixel x/y, kind, gray level, last
//   cfg_     input      cfg_we               cfg_index, cfg_data (seed loads)
//
// A respawning star passes S_READ, S_LOOK, S_SPAWN_X and S_SPAWN_Y. A live star
// is projected at its old depth and, if it survives, again at its new depth;
// each coordinate is one pass of the shared divider, 16 quotient steps long.
// Reset clears the star table's valid bits at once, so every star respawns.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register holds the sequencer only when the next result is due.
module starfield_projection_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sfp_pkg::COORD_W-1:0] out_pixel_x,
  output logic signed [sfp_pkg::COORD_W-1:0] out_pixel_y,
  output logic                              out_pixel_kind,
  output logic [sfp_pkg::DATA_W-1:0]        out_gray_level,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfp_pkg::DATA_W-1:0]        cfg_data
);
  import sfp_pkg::*;

  state_t state_r, state_nxt;

  star_t                mem [NUM_STARS];
  logic [NUM_STARS-1:0] vld_r;
  star_t                rd_word_r;
  logic                 rd_vld_r;
  logic                 mem_we;
  star_t                mem_wdata;

  logic [IDX_W-1:0]  cursor_r, cursor_nxt, cursor_inc;
  logic [DATA_W-1:0] spawn_r, spawn_nxt;
  logic [DATA_W-1:0] x_r, x_nxt, y_r, y_nxt, d_r, d_nxt, dn;
  logic              ph_r, ph_nxt, draw_ok_r, draw_ok_nxt, on_screen;
  logic signed [COORD_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [COORD_W-1:0] proj;

  logic                      out_valid_r, out_valid_nxt, out_load;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                      out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic [DATA_W-1:0]         out_gray_r, out_gray_nxt;

  logic              gen_step;
  logic [DATA_W-1:0] gen_val;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DATA_W-1:0] op_v, op_c;
  logic [DATA_W:0]   diff;
  star_t             rd_star;

  sfp_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (gen_step),
    .value     (gen_val)
  );

  sfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    op_v            = (state_r == S_DIV_Y || state_r == S_WAIT_Y) ? y_r : x_r;
    op_c            = (state_r == S_DIV_Y || state_r == S_WAIT_Y) ? CENTRE_Y : CENTRE_X;
    diff            = {1'b0, op_v} - {1'b0, op_c};
    div_req.start   = (state_r == S_DIV_X) || (state_r == S_DIV_Y);
    div_req.neg     = diff[DATA_W];
    div_req.mag     = diff[DATA_W] ? DATA_W'(~diff + 1'b1) : diff[DATA_W-1:0];
    div_req.den     = d_r;
  end

  always_comb begin
    cursor_inc = (cursor_r == IDX_W'(NUM_STARS - 1)) ? '0 : cursor_r + 1'b1;
    rd_star    = rd_vld_r ? rd_word_r : '0;
    dn         = d_r - DEPTH_STEP;
    proj       = div_rsp.quo + $signed({{(COORD_W - DATA_W){1'b0}}, op_c});
    on_screen  = !dx_r[COORD_W-1] && !dy_r[COORD_W-1] &&
                 ($unsigned(dx_r) < SCREEN_W) && ($unsigned(dy_r) < SCREEN_H);
    out_load   = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    spawn_nxt     = spawn_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    ph_nxt        = ph_r;
    draw_ok_nxt   = draw_ok_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    gen_step      = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '{x: x_r, y: y_r, depth: d_r};
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_kind_nxt  = out_kind_r;
    out_gray_nxt  = out_gray_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_frame_start) begin
            cursor_nxt = '0;
            spawn_nxt  = SPAWN_DEPTH0;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_LOOK;
      S_LOOK: begin
        x_nxt = rd_star.x;
        y_nxt = rd_star.y;
        d_nxt = rd_star.depth;
        if (rd_star.depth <= DEPTH_DEAD) begin
          state_nxt = S_SPAWN_X;
        end else begin
          ph_nxt    = 1'b0;
          state_nxt = S_DIV_X;
        end
      end
      S_SPAWN_X: begin
        gen_step  = 1'b1;
        x_nxt     = SPAWN_X_OFS + gen_val;
        state_nxt = S_SPAWN_Y;
      end
      S_SPAWN_Y: begin
        gen_step   = 1'b1;
        mem_we     = 1'b1;
        mem_wdata  = '{x: x_r, y: gen_val, depth: spawn_r};
        spawn_nxt  = spawn_r - 8'd1;
        cursor_nxt = cursor_inc;
        state_nxt  = S_IDLE;
      end
      S_DIV_X: state_nxt = S_WAIT_X;
      S_WAIT_X: begin
        if (div_rsp.done) begin
          if (ph_r) dx_nxt = proj;
          else      ex_nxt = proj;
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: state_nxt = S_WAIT_Y;
      S_WAIT_Y: begin
        if (div_rsp.done) begin
          if (ph_r) dy_nxt = proj;
          else      ey_nxt = proj;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!ph_r) begin
          d_nxt = dn;
          if (dn > DEPTH_DEAD) begin
            ph_nxt    = 1'b1;
            state_nxt = S_DIV_X;
          end else begin
            mem_we      = 1'b1;
            mem_wdata   = '{x: x_r, y: y_r, depth: dn};
            draw_ok_nxt = 1'b0;
            cursor_nxt  = cursor_inc;
            state_nxt   = S_EMIT_E;
          end
        end else begin
          mem_we      = 1'b1;
          mem_wdata   = '{x: x_r, y: y_r, depth: on_screen ? d_r : '0};
          draw_ok_nxt = on_screen;
          cursor_nxt  = cursor_inc;
          state_nxt   = S_EMIT_E;
        end
      end
      S_EMIT_E: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = ex_r;
          out_y_nxt     = ey_r;
          out_kind_nxt  = KIND_ERASE;
          out_gray_nxt  = '0;
          out_last_nxt  = !draw_ok_r;
          state_nxt     = draw_ok_r ? S_EMIT_D : S_IDLE;
        end
      end
      S_EMIT_D: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = dx_r;
          out_y_nxt     = dy_r;
          out_kind_nxt  = KIND_DRAW;
          out_gray_nxt  = GRAY_FULL - d_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      spawn_r     <= SPAWN_DEPTH0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      spawn_r     <= spawn_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) vld_r[cursor_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    d_r        <= d_nxt;
    ph_r       <= ph_nxt;
    draw_ok_r  <= draw_ok_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_kind_r <= out_kind_nxt;
    out_gray_r <= out_gray_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cursor_r] <= mem_wdata;
    rd_word_r <= mem[cursor_r];
    rd_vld_r  <= vld_r[cursor_r];
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_pixel_kind = out_kind_r;
  assign out_gray_level = out_gray_r;
  assign out_last       = out_last_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for starfield_projection_step: scripted and random star ticks scored against a local star table.
module tb;
  import sfp_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int PRINT_CAP     = 40;
  localparam int PROJ_SCALE    = 256;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    pixel_kind_t               kind;
    logic [DATA_W-1:0]         gray;
    logic                      last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_pixel_x;
  logic signed [COORD_W-1:0] out_pixel_y;
  logic out_pixel_kind;
  logic [DATA_W-1:0] out_gray_level;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int mismatch_count = 0;

  logic [DATA_W-1:0] tbl_x     [NUM_STARS];
  logic [DATA_W-1:0] tbl_y     [NUM_STARS];
  logic [DATA_W-1:0] tbl_depth [NUM_STARS];
  logic [DATA_W-1:0] gen_a, gen_b, gen_c, gen_count;
  logic [DATA_W-1:0] spawn_level;
  logic [IDX_W-1:0]  star_cursor;
  pixel_t pending_pixels[$];

  starfield_projection_step u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_kind (out_pixel_kind),
    .out_gray_level (out_gray_level),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic logic [DATA_W-1:0] gen_step();
    gen_count = gen_count + 1'b1;
    gen_a = gen_a ^ gen_c ^ gen_count;
    gen_b = gen_b + gen_a;
    gen_c = (gen_c + (gen_b >> 1)) ^ gen_a;
    return gen_c;
  endfunction

  function automatic int project_axis(input logic [DATA_W-1:0] v,
                                      input logic [DATA_W-1:0] centre,
                                      input logic [DATA_W-1:0] depth);
    int num;
    num = (int'(v) - int'(centre)) * PROJ_SCALE;
    return num / int'(depth) + int'(centre);
  endfunction

  function automatic void advance_starfield(input logic frame_start);
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] d;
    int px;
    int py;
    pixel_t wipe;
    pixel_t dot;
    logic shown;
    if (frame_start) begin
      star_cursor = '0;
      spawn_level = SPAWN_DEPTH0;
    end
    slot = star_cursor;
    if (tbl_depth[slot] <= DEPTH_DEAD) begin
      tbl_x[slot] = SPAWN_X_OFS + gen_step();
      tbl_y[slot] = gen_step();
      tbl_depth[slot] = spawn_level;
      spawn_level = spawn_level - 1'b1;
    end else begin
      d = tbl_depth[slot];
      wipe.x    = COORD_W'(project_axis(tbl_x[slot], CENTRE_X, d));
      wipe.y    = COORD_W'(project_axis(tbl_y[slot], CENTRE_Y, d));
      wipe.kind = KIND_ERASE;
      wipe.gray = '0;
      dot       = '0;
      shown     = 1'b0;
      d = d - DEPTH_STEP;
      tbl_depth[slot] = d;
      if (d > DEPTH_DEAD) begin
        px = project_axis(tbl_x[slot], CENTRE_X, d);
        py = project_axis(tbl_y[slot], CENTRE_Y, d);
        if (px >= 0 && py >= 0 && px < int'(SCREEN_W) && py < int'(SCREEN_H)) begin
          shown     = 1'b1;
          dot.x     = COORD_W'(px);
          dot.y     = COORD_W'(py);
          dot.kind  = KIND_DRAW;
          dot.gray  = GRAY_FULL - d;
          dot.last  = 1'b1;
        end else begin
          tbl_depth[slot] = '0;
        end
      end
      wipe.last = !shown;
      pending_pixels.push_back(wipe);
      if (shown) begin
        pending_pixels.push_back(dot);
      end
    end
    star_cursor = (int'(slot) + 1 >= NUM_STARS) ? '0 : slot + 1'b1;
  endfunction

  // hold the word until accepted
  task automatic send_tick(input logic frame_start);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_start <= frame_start;
    do @(posedge clk); while (!in_ready);
    advance_starfield(frame_start);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SEED_A:       gen_a = val;
      REG_SEED_B:       gen_b = val;
      REG_SEED_C:       gen_c = val;
      REG_SEED_COUNTER: gen_count = val;
      default: ;
    endcase
  endtask

  task automatic program_seeds(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                               input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] cnt);
    logic [CFG_IDX_W-1:0] spare;
    spare = REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 3));
    write_reg(REG_SEED_A, a);
    write_reg(REG_SEED_B, b);
    write_reg(REG_SEED_C, c);
    write_reg(REG_SEED_COUNTER, cnt);
    write_reg(spare, DATA_W'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    logic [7:0] plan_a;
    logic [7:0] plan_b;
    logic [7:0] plan_c;
    plan_a = 8'b1001_0011;
    plan_b = 8'b1100_1001;
    plan_c = 8'b1010_0100;
    for (int k = 7; k >= 0; k--) send_tick(plan_a[k]);
    drain_pixels();
    program_seeds(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    for (int k = 7; k >= 0; k--) send_tick(plan_b[k]);
    drain_pixels();
    program_seeds(8'h00, 8'hFF, 8'h00, 8'hFF);
    for (int k = 7; k >= 0; k--) send_tick(plan_c[k]);
    drain_pixels();
  endtask

  task automatic test_frame_overrun(input int n_ticks);
    send_tick(1'b1);
    repeat (n_ticks - 1) send_tick(1'b0);
  endtask

  task automatic test_short_frames(input int n_ticks);
    int sent;
    int len;
    sent = 0;
    while (sent < n_ticks) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int k = 0; k < len && sent < n_ticks; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_tick(1'($urandom_range(0, 1)));
        end else begin
          send_tick(k == 0);
        end
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word x=%0d y=%0d kind=%0b",
                                  out_pixel_x, out_pixel_y, out_pixel_kind));
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_pixel_x, want.x));
        if (out_pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_pixel_y, want.y));
        if (out_pixel_kind !== want.kind)
          report_mismatch($sformatf("pixel_kind got %0b want %0b", out_pixel_kind, want.kind));
        if (out_gray_level !== want.gray)
          report_mismatch($sformatf("gray_level got %0d want %0d", out_gray_level, want.gray));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
      end
    end
  end

  initial begin
    foreach (tbl_depth[i]) begin
      tbl_x[i]     = '0;
      tbl_y[i]     = '0;
      tbl_depth[i] = '0;
    end
    gen_a       = '0;
    gen_b       = '0;
    gen_c       = '0;
    gen_count   = '0;
    spawn_level = SPAWN_DEPTH0;
    star_cursor = '0;
    src_idle_pct  = 35;
    sink_idle_pct = 71;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    program_seeds(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                  DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
    test_frame_overrun(600);
    drain_pixels();

    src_idle_pct  = 71;
    sink_idle_pct = 35;
    program_seeds(8'h00, 8'h00, 8'h00, 8'h00);
    test_short_frames(180);
    drain_pixels();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    program_seeds(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                  DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
    test_short_frames(150);
    drain_pixels();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sfp_pkg.sv
rtl/sfp_gen.sv
rtl/sfp_div.sv
rtl/starfield_projection_step.sv
tb/tb.sv
